// ===== design/owtr_pkg.sv =====
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types and timing constants for the one-wire temperature read master.
// ----------------------------------------------------------------------------
`default_nettype none

package owtr_pkg;

  localparam int unsigned CountW = 20;
  localparam int unsigned TempW  = 16;
  localparam int unsigned RomW   = 64;

  localparam logic [CountW-1:0] RESET_LOW_US   = CountW'(480);
  localparam logic [CountW-1:0] PRESENCE_AT_US = CountW'(550);
  localparam logic [CountW-1:0] RESET_LAST_US  = CountW'(959);
  localparam logic [CountW-1:0] SLOT_LAST_US   = CountW'(69);
  localparam logic [CountW-1:0] WRITE1_LOW_US  = CountW'(6);
  localparam logic [CountW-1:0] WRITE0_LOW_US  = CountW'(60);
  localparam logic [CountW-1:0] READ_LOW_US    = CountW'(6);
  localparam logic [CountW-1:0] READ_SAMPLE_US = CountW'(15);
  localparam logic [CountW-1:0] CONV_WAIT_RST  = CountW'(750000);

  localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
  localparam logic [3:0] WRITE_BYTES   = 4'd10;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic REG_CONV_WAIT = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RESET = 3'd1,
    PH_WRITE = 3'd2,
    PH_WAIT  = 3'd3,
    PH_READ  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [CountW-1:0] count;
    logic [7:0]        shift;
    logic [2:0]        bit_idx;
    logic [3:0]        byte_idx;
    logic [RomW-1:0]   rom;
    logic              second;
    logic [TempW-1:0]  temp;
    logic              presence;
  } seq_state_t;

  typedef struct packed {
    logic line_low;
    logic busy;
    logic done;
  } seq_result_t;

endpackage

`default_nettype wire

// ===== design/one_wire_temperature_read_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_read_master
// One-wire bus master: match ROM, convert, wait, read the 16-bit temperature.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   command, rom_code, bus_level
// out_     output     out_valid/out_stall line_low, busy_res, done_res,
//                                         presence, temperature_raw
// cfg_     APB write  psel/penable/pready conversion_wait_us at address 0
//
// One transaction per clock unless the output stalls; each is settled in
// one pass into the result register; results appear in the next cycle.
// Reset (rst_n low, synchronous) idles the sequencer and empties the output.
// A stalled result holds and stalls the input only while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_temperature_read_master (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [owtr_pkg::RomW-1:0]       in_rom_code,
  input  logic                            in_bus_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_line_low,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic                            out_presence,
  output logic signed [owtr_pkg::TempW-1:0] out_temperature_raw,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import owtr_pkg::*;

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  seq_result_t       res;
  logic [CountW-1:0] conv_r;
  logic              out_valid_r;
  logic              line_low_r;
  logic              busy_r;
  logic              done_r;
  logic              presence_r;
  logic [TempW-1:0]  temp_r;
  logic              in_accept;
  logic              cfg_write;

  owtr_step u_step (
    .cur       (state_r),
    .command   (in_command),
    .rom_code  (in_rom_code),
    .bus_level (in_bus_level),
    .conv_wait (conv_r),
    .nxt       (state_nxt),
    .res       (res)
  );

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_CONV_WAIT);
  assign prdata    = (paddr[2] == REG_CONV_WAIT) ? {12'd0, conv_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      conv_r      <= CONV_WAIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        conv_r <= pwdata[CountW-1:0];
      end
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_low_r <= res.line_low;
      busy_r     <= res.busy;
      done_r     <= res.done;
      presence_r <= state_nxt.presence;
      temp_r     <= state_nxt.temp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_low        = line_low_r;
  assign out_busy_res        = busy_r;
  assign out_done_res        = done_r;
  assign out_presence        = presence_r;
  assign out_temperature_raw = signed'(temp_r);

endmodule

`default_nettype wire

// ===== design/owtr_step.sv =====
// ----------------------------------------------------------------------------
// owtr_step
// Next-state and result logic for one microsecond tick or start transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_step (
  input  owtr_pkg::seq_state_t          cur,
  input  logic                           command,
  input  logic [owtr_pkg::RomW-1:0]      rom_code,
  input  logic                           bus_level,
  input  logic [owtr_pkg::CountW-1:0]    conv_wait,
  output owtr_pkg::seq_state_t           nxt,
  output owtr_pkg::seq_result_t          res
);
  import owtr_pkg::*;

  function automatic logic [7:0] byte_to_send(input logic [3:0] idx,
                                              input logic [RomW-1:0] rom,
                                              input logic second);
    logic [2:0] sel;
    sel = 3'(idx - 4'd1);
    if (idx == 4'd0) begin
      return CMD_MATCH_ROM;
    end else if (idx <= 4'd8) begin
      return rom[{sel, 3'b000} +: 8];
    end else begin
      return second ? CMD_READ_PAD : CMD_CONVERT;
    end
  endfunction

  logic [CountW-1:0] c;
  logic [CountW-1:0] c_inc;
  logic [3:0]        byte_inc;
  logic [7:0]        shift_rd;
  logic              low;
  logic              done;

  assign c     = cur.count;
  assign c_inc = c + CountW'(1);
  assign byte_inc = cur.byte_idx + 4'd1;
  assign shift_rd = (c == READ_SAMPLE_US) ? {bus_level, cur.shift[7:1]} : cur.shift;

  always_comb begin
    nxt  = cur;
    low  = 1'b0;
    done = 1'b0;
    if (command == CMD_START) begin
      if (cur.phase == PH_IDLE) begin
        nxt.rom    = rom_code;
        nxt.second = 1'b0;
        nxt.phase  = PH_RESET;
        nxt.count  = '0;
      end
    end else begin
      case (cur.phase)
        PH_IDLE: begin
        end
        PH_RESET: begin
          low = (c < RESET_LOW_US);
          if (c == PRESENCE_AT_US) begin
            nxt.presence = ~bus_level;
          end
          if (c >= RESET_LAST_US) begin
            nxt.phase    = PH_WRITE;
            nxt.count    = '0;
            nxt.bit_idx  = '0;
            nxt.byte_idx = '0;
            nxt.shift    = CMD_MATCH_ROM;
          end else begin
            nxt.count = c_inc;
          end
        end
        PH_WRITE: begin
          low = (c < (cur.shift[0] ? WRITE1_LOW_US : WRITE0_LOW_US));
          if (c >= SLOT_LAST_US) begin
            nxt.count   = '0;
            nxt.shift   = {1'b0, cur.shift[7:1]};
            nxt.bit_idx = cur.bit_idx + 3'd1;
            if (cur.bit_idx == 3'd7) begin
              if (byte_inc >= WRITE_BYTES) begin
                nxt.byte_idx = '0;
                if (cur.second) begin
                  nxt.phase = PH_READ;
                  nxt.shift = '0;
                end else if (conv_wait == '0) begin
                  nxt.second = 1'b1;
                  nxt.phase  = PH_RESET;
                end else begin
                  nxt.phase = PH_WAIT;
                end
              end else begin
                nxt.byte_idx = byte_inc;
                nxt.shift    = byte_to_send(byte_inc, cur.rom, cur.second);
              end
            end
          end else begin
            nxt.count = c_inc;
          end
        end
        PH_WAIT: begin
          if (c_inc >= conv_wait) begin
            nxt.second = 1'b1;
            nxt.phase  = PH_RESET;
            nxt.count  = '0;
          end else begin
            nxt.count = c_inc;
          end
        end
        PH_READ: begin
          low       = (c < READ_LOW_US);
          nxt.shift = shift_rd;
          if (c >= SLOT_LAST_US) begin
            nxt.count   = '0;
            nxt.bit_idx = cur.bit_idx + 3'd1;
            if (cur.bit_idx == 3'd7) begin
              if (cur.byte_idx == 4'd0) begin
                nxt.temp[7:0] = shift_rd;
                nxt.byte_idx  = 4'd1;
                nxt.shift     = '0;
              end else begin
                nxt.temp[15:8] = shift_rd;
                nxt.byte_idx   = '0;
                nxt.second     = 1'b0;
                nxt.phase      = PH_IDLE;
                done           = 1'b1;
              end
            end
          end else begin
            nxt.count = c_inc;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
          nxt.count = '0;
        end
      endcase
    end
  end

  assign res.line_low = low;
  assign res.busy     = (nxt.phase != PH_IDLE);
  assign res.done     = done;

endmodule

`default_nettype wire

// ===== design/owtr_checker.sv =====
// ----------------------------------------------------------------------------
// owtr_checker
// Port-level assertions for the one-wire temperature read master.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_line_low,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [15:0] out_temperature_raw
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled behind a waiting result");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_line_low)
    else $error("done while still busy or driving");

  a_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_low |-> out_busy_res)
    else $error("line driven while idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature_raw)
                               && $stable(out_done_res))
    else $error("stalled transaction changed");

endmodule

bind one_wire_temperature_read_master owtr_checker u_owtr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_line_low        (out_line_low),
  .out_busy_res        (out_busy_res),
  .out_done_res        (out_done_res),
  .out_temperature_raw (out_temperature_raw)
);

`default_nettype wire
